FILE: design/tte_pkg.sv
// Shared constants and helpers for the tap tempo estimator.
// No dependencies; imported by tte_div3 and tap_tempo_estimator.
package tte_pkg;

  // Sequencer resolution and the beat step of one quarter bar
  localparam int BeatsPerBar = 16;
  localparam int BeatStep    = BeatsPerBar / 4;

  // Field widths
  localparam int TimeW  = 32;
  localparam int BeatW  = 8;
  localparam int AccW   = TimeW + 2;   // 2*estimate + interval
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxInterval = 2'd1;

  // Tap phase codes: which tap of the four-tap sequence comes next
  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhThird  = 2'd2;
  localparam logic [1:0] PhFourth = 2'd3;

  // Divide by three: q = (x * ceil(2^36/3)) >> 36, exact for x < 2^34
  localparam int DivMulW   = 35;
  localparam logic [DivMulW-1:0] DivMul = 35'h5_5555_5556;
  localparam int DivShift  = 36;
  localparam int DivLoW    = AccW / 2;
  localparam int DivHiW    = AccW - DivLoW;
  localparam int DivProdW  = AccW + DivMulW;

  // Beat position of a tap: quarter index times the quarter step
  function automatic logic [BeatW-1:0] beat_of(input logic [1:0] quarter);
    int prod;
    prod = BeatStep * int'(quarter);
    return prod[BeatW-1:0];
  endfunction

endpackage

FILE: design/tte_div3.sv
// Two-step divide-by-three of the tap-4 weighted sum.
// Depends on tte_pkg; partial products are registered, the final add is combinational.
module tte_div3 (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tte_pkg::AccW-1:0]  x_i,
  output logic [tte_pkg::TimeW-1:0] q_o
);
  import tte_pkg::*;

  logic [DivLoW+DivMulW-1:0] lo_prod_q;
  logic [DivHiW+DivMulW-1:0] hi_prod_q;
  logic [DivProdW-1:0]       sum;

  // Split multiply by the reciprocal into two narrow partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_prod_q <= x_i[DivLoW-1:0] * DivMul;
      hi_prod_q <= x_i[AccW-1:DivLoW] * DivMul;
    end
  end

  // Recombine and keep the quotient bits
  assign sum = DivProdW'(lo_prod_q) + {hi_prod_q, {DivLoW{1'b0}}};
  assign q_o = sum[DivShift +: TimeW];

endmodule

FILE: design/tap_tempo_estimator.sv
// Tap tempo estimator, top level: input stage, tap compute stage,
// divide stage and output register. Depends on tte_pkg and tte_div3.
//
// Usage:
//   Taps arrive on the in channel (tap_time_i, valid/ready); each beat is one
//   tap timestamp from a free-running tick counter. Every tap that is not a
//   glitch yields one result beat on the out channel: beat position, tempo
//   estimate and show/apply flags. Glitch taps yield nothing.
//   min_interval and max_interval are written on the cfg channel (index 0 and
//   1); cfg_ready_o is always high. Write them only while the block is idle.
// Timing:
//   Four register stages: input, tap compute, divide, output. A result beat
//   passes through each of them in turn on its way to the out port.
//   Throughput is one tap per cycle while the out channel does not stall: the
//   phase, last time and estimate are updated in the single compute stage, and
//   the divide by three after the fourth tap is pipelined behind it.
// Reset and stalls:
//   Reset clears all valid bits, the tap phase (next tap is the first), the
//   last tap time, the estimate and both registers to their defaults.
//   When the receiver stalls, the stages fill up; in_ready_o drops only when
//   every stage holds a beat.
module tap_tempo_estimator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tte_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tte_pkg::TimeW-1:0]   cfg_data_i,
  // tap input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tte_pkg::TimeW-1:0]   tap_time_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tte_pkg::BeatW-1:0]   beat_position_o,
  output logic [tte_pkg::TimeW-1:0]   tempo_value_o,
  output logic                        show_tempo_o,
  output logic                        apply_tempo_o
);
  import tte_pkg::*;

  // Configuration registers
  logic [TimeW-1:0] min_q, max_q;

  // Tap state
  logic [1:0]       phase_q, phase_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] est_q, est_d;
  logic             pend_q, pend_d;        // estimate awaits divide by three
  logic [AccW-1:0]  pend_acc_q, pend_acc_d;

  // Pipeline stages
  logic             s0_v_q;
  logic [TimeW-1:0] s0_time_q;
  logic             s1_v_q;
  logic [BeatW-1:0] s1_beat_q, s1_beat_d;
  logic             s1_show_q, s1_show_d;
  logic             s1_apply_q, s1_apply_d;
  logic             s1_div_q, s1_div_d;
  logic [AccW-1:0]  s1_val_q, s1_val_d;
  logic             s2_v_q;
  logic [BeatW-1:0] s2_beat_q;
  logic             s2_show_q, s2_apply_q, s2_div_q;
  logic [TimeW-1:0] s2_direct_q;
  logic [TimeW-1:0] div_q;
  logic             out_v_q;
  logic [BeatW-1:0] out_beat_q;
  logic [TimeW-1:0] out_tempo_q;
  logic             out_show_q, out_apply_q;

  // Stage advance chain
  logic adv0, adv1, adv2, adv3;
  logic [TimeW-1:0] interval;
  logic [TimeW:0]   half_sum;
  logic [AccW-1:0]  wsum;
  logic             glitch, restart, step;

  assign adv3 = !out_v_q || out_ready_i;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;
  assign adv0 = !s0_v_q || adv1;
  assign in_ready_o  = adv0;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinInterval: min_q <= cfg_data_i;
        CfgMaxInterval: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv0) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv0) begin
      s0_time_q <= tap_time_i;
    end
  end

  // Tap compute: interval checks, estimate update, result fields
  assign interval = s0_time_q - last_q;
  assign half_sum = {1'b0, est_q} + {1'b0, interval};
  assign wsum     = {1'b0, est_q, 1'b0} + AccW'(interval);
  assign glitch   = (phase_q != PhFirst) && (interval < min_q);
  assign restart  = (phase_q == PhFirst) || (interval > max_q);
  assign step     = s0_v_q && adv1 && !glitch;

  always_comb begin
    phase_d    = phase_q;
    last_d     = last_q;
    est_d      = est_q;
    pend_d     = pend_q;
    pend_acc_d = pend_acc_q;
    s1_beat_d  = beat_of(phase_q);
    s1_show_d  = 1'b1;
    s1_apply_d = 1'b0;
    s1_div_d   = 1'b0;
    s1_val_d   = '0;
    if (restart) begin
      // first tap of a sequence: report the standing estimate
      phase_d    = PhSecond;
      last_d     = s0_time_q;
      s1_beat_d  = beat_of(PhFirst);
      s1_show_d  = 1'b0;
      s1_div_d   = pend_q;
      s1_val_d   = pend_q ? pend_acc_q : AccW'(est_q);
    end else begin
      last_d = s0_time_q;
      case (phase_q)
        PhSecond: begin
          phase_d  = PhThird;
          est_d    = interval;
          pend_d   = 1'b0;
          s1_val_d = AccW'(interval);
        end
        PhThird: begin
          phase_d  = PhFourth;
          est_d    = half_sum[TimeW:1];
          s1_val_d = AccW'(half_sum[TimeW:1]);
        end
        default: begin
          // fourth tap: weighted mean, divided downstream
          phase_d    = PhFirst;
          pend_d     = 1'b1;
          pend_acc_d = wsum;
          s1_apply_d = 1'b1;
          s1_div_d   = 1'b1;
          s1_val_d   = wsum;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      last_q  <= '0;
      est_q   <= '0;
      pend_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      last_q  <= last_d;
      est_q   <= est_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pend_acc_q <= pend_acc_d;
    end
  end

  // Compute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv1) begin
      s1_v_q <= s0_v_q && !glitch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_beat_q  <= s1_beat_d;
      s1_show_q  <= s1_show_d;
      s1_apply_q <= s1_apply_d;
      s1_div_q   <= s1_div_d;
      s1_val_q   <= s1_val_d;
    end
  end

  // Divide stage
  tte_div3 u_div3 (
    .clk_i (clk_i),
    .en_i  (adv2),
    .x_i   (s1_val_q),
    .q_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_beat_q   <= s1_beat_q;
      s2_show_q   <= s1_show_q;
      s2_apply_q  <= s1_apply_q;
      s2_div_q    <= s1_div_q;
      s2_direct_q <= s1_val_q[TimeW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv3) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_beat_q  <= s2_beat_q;
      out_show_q  <= s2_show_q;
      out_apply_q <= s2_apply_q;
      out_tempo_q <= s2_div_q ? div_q : s2_direct_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign beat_position_o = out_beat_q;
  assign tempo_value_o   = out_tempo_q;
  assign show_tempo_o    = out_show_q;
  assign apply_tempo_o   = out_apply_q;

`ifndef SYNTH
  // apply only comes with a shown tempo
  a_apply_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_apply_q |-> out_show_q)
    else $error("apply without show");

  // a pending divide only lives before the next second tap
  a_pend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q == PhFirst || phase_q == PhSecond))
    else $error("pending estimate in late phase");

  // a fourth tap wraps the phase and leaves the sum pending
  a_fourth_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !restart && phase_q == PhFourth |=> pend_q && phase_q == PhFirst)
    else $error("fourth tap did not wrap");

  // a first-tap result sits at the bar start with no flags
  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_show_q |-> s1_beat_q == beat_of(PhFirst) && !s1_apply_q)
    else $error("first tap result malformed");
`endif

endmodule
